@@ hdl/store_bus_cycle_sequencer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Store bus cycle sequencer assertion macros
// Concurrent check wrappers on clk_i, disabled while rst_ni is low; empty
// bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STORE_BUS_CYCLE_SEQUENCER_TOP_DEFINES_SVH
`define STORE_BUS_CYCLE_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTH
`define SBCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbcs check failed");
`define SBCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbcs check failed");
`else
`define SBCS_ASSERT_IMP(lbl, ante, cons)
`define SBCS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hdl/sbcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Store bus cycle sequencer package
// Shared types and constants for the sequencer step logic and top level.
// ----------------------------------------------------------------------------
package sbcs_pkg;

  // command codes carried with each input word
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [15:0] PC_STEP_ZP  = 16'd1;
  localparam logic [15:0] PC_STEP_ABS = 16'd2;

  typedef enum logic [2:0] {
    MODE_ZP     = 3'd0,
    MODE_ZP_X   = 3'd1,
    MODE_ZP_Y   = 3'd2,
    MODE_ABS    = 3'd3,
    MODE_ABS_X  = 3'd4,
    MODE_ABS_Y  = 3'd5,
    MODE_IND_X  = 3'd6,
    MODE_IND_Y  = 3'd7
  } mode_e;

  typedef struct packed {
    logic        busy;
    logic [2:0]  phase;
    mode_e       mode;
    logic [7:0]  value;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] pc;
    logic [7:0]  base;
    logic [7:0]  ptr_lo;
    logic [7:0]  ptr_hi;
  } state_t;

  typedef struct packed {
    logic [15:0] addr;
    logic        write;
    logic [7:0]  wdata;
    logic        dummy;
    logic        last;
    logic [15:0] next_pc;
  } result_t;

endpackage

@@ hdl/sbcs_step.sv @@
// ----------------------------------------------------------------------------
// Store bus cycle sequencer step
// Next state and bus access for one input word, given the current state.
// ----------------------------------------------------------------------------
module sbcs_step (
  input  sbcs_pkg::state_t  st_i,
  input  logic              command_i,
  input  logic [2:0]        mode_i,
  input  logic [7:0]        store_value_i,
  input  logic [7:0]        index_x_i,
  input  logic [7:0]        index_y_i,
  input  logic [15:0]       program_counter_i,
  input  logic [7:0]        read_data_i,
  output sbcs_pkg::state_t  st_o,
  output sbcs_pkg::result_t res_o,
  output logic              emit_o
);
  import sbcs_pkg::*;

  logic [2:0]  k;
  logic [2:0]  kp;
  logic [7:0]  idx;
  logic [7:0]  zp;
  logic [15:0] hi_word;
  logic [15:0] addr;
  logic        wr;
  logic        dmy;

  always_comb begin
    st_o    = st_i;
    res_o   = '0;
    emit_o  = 1'b0;
    k       = st_i.phase;
    kp      = k - 3'd1;
    idx     = '0;
    zp      = '0;
    hi_word = '0;
    addr    = '0;
    wr      = 1'b0;
    dmy     = 1'b0;

    if (command_i == CMD_START) begin
      // latch the instruction and fetch the first operand byte
      st_o.mode   = mode_e'(mode_i);
      st_o.value  = store_value_i;
      st_o.x      = index_x_i;
      st_o.y      = index_y_i;
      st_o.pc     = program_counter_i;
      st_o.base   = '0;
      st_o.ptr_lo = '0;
      st_o.ptr_hi = '0;
      st_o.busy   = 1'b1;
      st_o.phase  = 3'd1;
      res_o.addr  = program_counter_i;
      emit_o      = 1'b1;
    end else if (st_i.busy) begin
      // capture the byte of the previous read
      if (kp == 3'd0) begin
        st_o.base = read_data_i;
      end else begin
        unique case (st_i.mode)
          MODE_ABS, MODE_ABS_X, MODE_ABS_Y: begin
            if (kp == 3'd1) st_o.ptr_hi = read_data_i;
          end
          MODE_IND_X: begin
            if (kp == 3'd2) st_o.ptr_lo = read_data_i;
            else if (kp == 3'd3) st_o.ptr_hi = read_data_i;
          end
          MODE_IND_Y: begin
            if (kp == 3'd1) st_o.ptr_lo = read_data_i;
            else if (kp == 3'd2) st_o.ptr_hi = read_data_i;
          end
          default: begin
          end
        endcase
      end
      st_o.phase = k + 3'd1;

      idx = (st_i.mode == MODE_ZP_X || st_i.mode == MODE_ABS_X ||
             st_i.mode == MODE_IND_X) ? st_i.x : st_i.y;
      hi_word = {st_o.ptr_hi, 8'h00};

      unique case (st_i.mode)
        MODE_ZP: begin
          addr = {8'h00, st_o.base};
          wr   = 1'b1;
        end
        MODE_ZP_X, MODE_ZP_Y: begin
          if (k == 3'd1) begin
            addr = {8'h00, st_o.base};
            dmy  = 1'b1;
          end else begin
            zp   = st_o.base + idx;
            addr = {8'h00, zp};
            wr   = 1'b1;
          end
        end
        MODE_ABS: begin
          if (k == 3'd1) begin
            addr = st_i.pc + 16'd1;
          end else begin
            addr = {st_o.ptr_hi, st_o.base};
            wr   = 1'b1;
          end
        end
        MODE_ABS_X, MODE_ABS_Y: begin
          if (k == 3'd1) begin
            addr = st_i.pc + 16'd1;
          end else if (k == 3'd2) begin
            zp   = st_o.base + idx;
            addr = hi_word | {8'h00, zp};
            dmy  = 1'b1;
          end else begin
            addr = {st_o.ptr_hi, st_o.base} + {8'h00, idx};
            wr   = 1'b1;
          end
        end
        MODE_IND_X: begin
          zp = st_o.base + idx;
          if (k == 3'd1) begin
            addr = {8'h00, st_o.base};
            dmy  = 1'b1;
          end else if (k == 3'd2) begin
            addr = {8'h00, zp};
          end else if (k == 3'd3) begin
            addr = {8'h00, zp + 8'd1};
          end else begin
            addr = {st_o.ptr_hi, st_o.ptr_lo};
            wr   = 1'b1;
          end
        end
        MODE_IND_Y: begin
          if (k == 3'd1) begin
            addr = {8'h00, st_o.base};
          end else if (k == 3'd2) begin
            addr = {8'h00, st_o.base + 8'd1};
          end else if (k == 3'd3) begin
            zp   = st_o.ptr_lo + idx;
            addr = hi_word | {8'h00, zp};
            dmy  = 1'b1;
          end else begin
            addr = {st_o.ptr_hi, st_o.ptr_lo} + {8'h00, idx};
            wr   = 1'b1;
          end
        end
        default: begin
        end
      endcase

      res_o.addr  = addr;
      res_o.write = wr;
      res_o.dummy = dmy;
      res_o.last  = wr;
      emit_o      = 1'b1;
      if (wr) begin
        // final write: hand back the PC past the operand bytes and go idle
        res_o.wdata   = st_i.value;
        res_o.next_pc = st_i.pc + ((st_i.mode == MODE_ABS || st_i.mode == MODE_ABS_X ||
                                    st_i.mode == MODE_ABS_Y) ? PC_STEP_ABS : PC_STEP_ZP);
        st_o.busy     = 1'b0;
        st_o.phase    = 3'd0;
      end
    end
  end

endmodule

@@ hdl/store_bus_cycle_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// Store bus cycle sequencer
// Drives the bus accesses of 6502 store instructions one word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): a start word (command 0) loads
//   mode, store value, X, Y and PC and yields the operand fetch at PC. Each
//   data word (command 1) returns the byte of the previous bus read and
//   yields the next access, up to the write marked last, which carries the
//   PC past the operand bytes. A data word while idle is taken and dropped.
//   A start word while an instruction runs abandons it and starts anew.
//   Output channel (out_valid_o / out_stall_i): one word per bus access.
//   The access for a word shows on the output in the cycle after the word
//   is accepted; all step logic sits between the sequencer state register
//   and the output register.
//   Throughput: one word per cycle unless the output stalls.
//   While the output word is stalled, in_stall_o is raised and the output
//   register holds; a drained output register takes a new word in the same
//   cycle, so no bubble appears.
//   Reset clears the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
`include "store_bus_cycle_sequencer_top_defines.svh"

module store_bus_cycle_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  store_value_i,
  input  logic [7:0]  index_x_i,
  input  logic [7:0]  index_y_i,
  input  logic [15:0] program_counter_i,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] bus_address_o,
  output logic        bus_write_o,
  output logic [7:0]  write_data_o,
  output logic        dummy_cycle_o,
  output logic        last_o,
  output logic [15:0] next_pc_o
);
  import sbcs_pkg::*;

  state_t  state_q;
  state_t  state_d;
  result_t step_res;
  result_t res_q;
  logic    step_emit;
  logic    out_valid_q;
  logic    out_valid_d;
  logic    in_acc;
  logic    out_load;

  // hold input while the output word is stuck
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_load   = in_acc & step_emit;

  sbcs_step u_step (
    .st_i              (state_q),
    .command_i         (command_i),
    .mode_i            (mode_i),
    .store_value_i     (store_value_i),
    .index_x_i         (index_x_i),
    .index_y_i         (index_y_i),
    .program_counter_i (program_counter_i),
    .read_data_i       (read_data_i),
    .st_o              (state_d),
    .res_o             (step_res),
    .emit_o            (step_emit)
  );

  // output valid: set on load, drop once the word is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        state_q <= state_d;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bus_address_o = res_q.addr;
  assign bus_write_o   = res_q.write;
  assign write_data_o  = res_q.wdata;
  assign dummy_cycle_o = res_q.dummy;
  assign last_o        = res_q.last;
  assign next_pc_o     = res_q.next_pc;

  `SBCS_ASSERT_IMP(a_idle_phase_zero, !state_q.busy, state_q.phase == 3'd0)
  `SBCS_ASSERT_IMP(a_read_no_pc, out_valid_o && !bus_write_o,
                   next_pc_o == 16'd0 && write_data_o == 8'd0 && !last_o)
  `SBCS_ASSERT_NXT(a_start_busy, in_acc && command_i == CMD_START,
                   state_q.busy && state_q.phase == 3'd1 && out_valid_o && !bus_write_o)
  `SBCS_ASSERT_NXT(a_write_idles, out_load && step_res.write, !state_q.busy)

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Store bus cycle sequencer testbench
// Drives start and read-data words into the sequencer and predicts every bus
// access it yields. Each access is compared field by field with the oldest
// prediction. Stimulus covers directed wrap and carry corners for each
// addressing mode, a back-to-back stream, a long output hold-off that fills
// the block, and a long random run of store sequences mixed with noise.
// ----------------------------------------------------------------------------
module testbench;
  import sbcs_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  // Clock, reset and block ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = CMD_START;
  logic [2:0]  mode = '0;
  logic [7:0]  store_value = '0;
  logic [7:0]  index_x = '0;
  logic [7:0]  index_y = '0;
  logic [15:0] program_counter = '0;
  logic [7:0]  read_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] bus_address;
  logic        bus_write;
  logic [7:0]  write_data;
  logic        dummy_cycle;
  logic        last;
  logic [15:0] next_pc;

  // Predicted sequencer state
  logic        sq_busy = 1'b0;
  logic [2:0]  sq_phase = '0;
  mode_e       sq_mode = MODE_ZP;
  logic [7:0]  sq_value = '0;
  logic [7:0]  sq_x = '0;
  logic [7:0]  sq_y = '0;
  logic [15:0] sq_pc = '0;
  logic [7:0]  sq_base = '0;
  logic [7:0]  sq_lo = '0;
  logic [7:0]  sq_hi = '0;

  result_t expected_accesses [$];

  // Run statistics and error count
  int n_accesses = 0;
  int n_checked = 0;
  int n_dummy = 0;
  int n_idle_drops = 0;
  int n_restarts = 0;
  int n_errors = 0;
  int writes_per_mode [8] = '{default: 0};
  int cycles = 0;

  // Receiver controls: gaps_on enables random idling on both sides,
  // hold_request asks the receiver for one long hold-off
  bit gaps_on = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  int burst_left = 0;

  store_bus_cycle_sequencer_top DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .command_i         (command),
    .mode_i            (mode),
    .store_value_i     (store_value),
    .index_x_i         (index_x),
    .index_y_i         (index_y),
    .program_counter_i (program_counter),
    .read_data_i       (read_data),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .bus_address_o     (bus_address),
    .bus_write_o       (bus_write),
    .write_data_o      (write_data),
    .dummy_cycle_o     (dummy_cycle),
    .last_o            (last),
    .next_pc_o         (next_pc)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Number of data words that follow the start word of a full instruction
  function automatic int data_words(mode_e m);
    case (m)
      MODE_ZP:                      return 1;
      MODE_ZP_X, MODE_ZP_Y, MODE_ABS: return 2;
      MODE_ABS_X, MODE_ABS_Y:       return 3;
      default:                      return 4;
    endcase
  endfunction

  // Advance the predicted sequencer by one accepted word and queue the bus
  // access it yields; a data word while idle yields nothing.
  function automatic void step_sequencer(input logic cmd, input logic [2:0] m,
      input logic [7:0] value, input logic [7:0] x, input logic [7:0] y,
      input logic [15:0] pc, input logic [7:0] rd);
    result_t    acc;
    logic [2:0] k;
    logic [7:0] idx;
    logic [7:0] zp;
    logic [7:0] zp_next;
    logic [7:0] base_next;
    logic [7:0] lo_idx;
    bit         abs_mode;
    acc = '0;
    if (cmd == CMD_START) begin
      if (sq_busy) n_restarts++;
      sq_mode  = mode_e'(m);
      sq_value = value;
      sq_x     = x;
      sq_y     = y;
      sq_pc    = pc;
      sq_base  = '0;
      sq_lo    = '0;
      sq_hi    = '0;
      sq_busy  = 1'b1;
      sq_phase = 3'd1;
      acc.addr = pc;
      expected_accesses.push_back(acc);
      n_accesses++;
      return;
    end
    if (!sq_busy) begin
      n_idle_drops++;
      return;
    end
    k = sq_phase;
    abs_mode = (sq_mode == MODE_ABS || sq_mode == MODE_ABS_X || sq_mode == MODE_ABS_Y);
    // Latch the byte of the read that access k-1 made; dummy data is dropped
    if (k == 3'd1) begin
      sq_base = rd;
    end else if (abs_mode) begin
      if (k == 3'd2) sq_hi = rd;
    end else if (sq_mode == MODE_IND_X) begin
      if (k == 3'd3) sq_lo = rd;
      else if (k == 3'd4) sq_hi = rd;
    end else if (sq_mode == MODE_IND_Y) begin
      if (k == 3'd2) sq_lo = rd;
      else if (k == 3'd3) sq_hi = rd;
    end
    sq_phase = k + 3'd1;

    idx = (sq_mode == MODE_ZP_X || sq_mode == MODE_ABS_X || sq_mode == MODE_IND_X) ? sq_x : sq_y;
    zp        = sq_base + idx;
    zp_next   = zp + 8'd1;
    base_next = sq_base + 8'd1;
    lo_idx    = sq_lo + idx;

    case (sq_mode)
      MODE_ZP: begin
        acc.write = 1'b1;
        acc.addr  = {8'h00, sq_base};
      end
      MODE_ZP_X, MODE_ZP_Y: begin
        if (k == 3'd1) begin
          acc.addr  = {8'h00, sq_base};
          acc.dummy = 1'b1;
        end else begin
          acc.write = 1'b1;
          acc.addr  = {8'h00, zp};
        end
      end
      MODE_ABS: begin
        if (k == 3'd1) begin
          acc.addr = sq_pc + 16'd1;
        end else begin
          acc.write = 1'b1;
          acc.addr  = {sq_hi, sq_base};
        end
      end
      MODE_ABS_X, MODE_ABS_Y: begin
        if (k == 3'd1) begin
          acc.addr = sq_pc + 16'd1;
        end else if (k == 3'd2) begin
          // un-carried address first, the real one on the write
          acc.addr  = {sq_hi, zp};
          acc.dummy = 1'b1;
        end else begin
          acc.write = 1'b1;
          acc.addr  = {sq_hi, sq_base} + {8'h00, idx};
        end
      end
      MODE_IND_X: begin
        if (k == 3'd1) begin
          acc.addr  = {8'h00, sq_base};
          acc.dummy = 1'b1;
        end else if (k == 3'd2) begin
          acc.addr = {8'h00, zp};
        end else if (k == 3'd3) begin
          acc.addr = {8'h00, zp_next};
        end else begin
          acc.write = 1'b1;
          acc.addr  = {sq_hi, sq_lo};
        end
      end
      default: begin
        if (k == 3'd1) begin
          acc.addr = {8'h00, sq_base};
        end else if (k == 3'd2) begin
          acc.addr = {8'h00, base_next};
        end else if (k == 3'd3) begin
          acc.addr  = {sq_hi, lo_idx};
          acc.dummy = 1'b1;
        end else begin
          acc.write = 1'b1;
          acc.addr  = {sq_hi, sq_lo} + {8'h00, idx};
        end
      end
    endcase

    if (acc.write) begin
      acc.wdata   = sq_value;
      acc.last    = 1'b1;
      acc.next_pc = sq_pc + (abs_mode ? PC_STEP_ABS : PC_STEP_ZP);
      writes_per_mode[int'(sq_mode)]++;
      sq_busy  = 1'b0;
      sq_phase = '0;
    end
    if (acc.dummy) n_dummy++;
    expected_accesses.push_back(acc);
    n_accesses++;
  endfunction

  // Drop valid for a random gap: mostly none, sometimes short, rarely long.
  // Call only at a rising edge, right after a word was accepted or at start.
  task automatic idle_between();
    int roll;
    int n;
    if (!gaps_on) return;
    roll = $urandom_range(0, 99);
    if (roll < 70) n = 0;
    else if (roll < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one word, hold it until accepted, then advance the prediction
  task automatic send_word(input logic cmd, input logic [2:0] m, input logic [7:0] value,
      input logic [7:0] x, input logic [7:0] y, input logic [15:0] pc,
      input logic [7:0] rd);
    in_valid        <= 1'b1;
    command         <= cmd;
    mode            <= m;
    store_value     <= value;
    index_x         <= x;
    index_y         <= y;
    program_counter <= pc;
    read_data       <= rd;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    step_sequencer(cmd, m, value, x, y, pc, rd);
  endtask

  // One store instruction: the start word, then 'words' data words carrying
  // the bytes of 'fetched', lowest byte first. Fewer words than the mode
  // needs leave the instruction running.
  task automatic run_store(input logic [2:0] m, input logic [7:0] value,
      input logic [7:0] x, input logic [7:0] y, input logic [15:0] pc,
      input logic [31:0] fetched, input int words);
    int i;
    idle_between();
    send_word(CMD_START, m, value, x, y, pc, 8'($urandom));
    for (i = 0; i < words; i++) begin
      idle_between();
      // fill the fields a data word ignores with junk
      send_word(CMD_DATA, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                16'($urandom), fetched[8*i +: 8]);
    end
  endtask

  // Corners: idle drops, 8-bit and 16-bit wraps, carries, restart when busy
  task automatic test_directed_edges();
    send_word(CMD_DATA, MODE_IND_Y, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    run_store(MODE_ZP, 8'hFF, 8'h00, 8'h00, 16'hFFFF, 32'h0000_00FF, 1);
    run_store(MODE_ZP_X, 8'h00, 8'hFF, 8'h00, 16'h0000, 32'h0000_00FF, 2);
    run_store(MODE_ZP_Y, 8'hA5, 8'h00, 8'h01, 16'h1234, 32'h0000_00FF, 2);
    run_store(MODE_ABS, 8'h00, 8'h00, 8'h00, 16'hFFFF, 32'h0000_80FF, 2);
    // abandon after the low byte, then restart with a carry into the high byte
    run_store(MODE_ABS_X, 8'h5A, 8'h01, 8'h00, 16'h4000, 32'h0000_00FF, 1);
    run_store(MODE_ABS_X, 8'h3C, 8'h01, 8'h00, 16'hFFFE, 32'h0000_12FF, 3);
    run_store(MODE_ABS_Y, 8'hC3, 8'h00, 8'hFF, 16'h8000, 32'h0000_FFFF, 3);
    run_store(MODE_IND_X, 8'h81, 8'h7F, 8'hFF, 16'h00FF, 32'h1234_AA80, 4);
    run_store(MODE_IND_Y, 8'h7E, 8'hFF, 8'h01, 16'hFFFF, 32'h007F_FFFF, 4);
    send_word(CMD_DATA, MODE_ZP, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00);
  endtask

  // Full instructions back to back with no idling on either side
  task automatic test_steady_stream(input int count);
    int i;
    logic [2:0] m;
    gaps_on = 1'b0;
    for (i = 0; i < count; i++) begin
      m = 3'($urandom);
      run_store(m, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                data_words(mode_e'(m)));
    end
    gaps_on = 1'b1;
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // block fills and stalls its input
  task automatic test_output_holdoff(input int count);
    int i;
    logic [2:0] m;
    gaps_on = 1'b0;
    hold_request = 60;
    for (i = 0; i < count; i++) begin
      m = 3'($urandom);
      run_store(m, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                data_words(mode_e'(m)));
    end
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed instructions with random content; some cut short,
  // the rest stray data words that land while idle or mid-sequence
  task automatic test_random_stores(input int target);
    int goal;
    int n;
    int i;
    logic [2:0] m;
    goal = n_accesses + target;
    while (n_accesses < goal) begin
      if ($urandom_range(0, 19) == 0) gaps_on = ~gaps_on;
      m = 3'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        n = data_words(mode_e'(m));
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
        run_store(m, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), $urandom, n);
      end else begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
          idle_between();
          send_word(CMD_DATA, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom), 8'($urandom));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: honor a long hold-off when asked, otherwise stall in random
  // bursts (mostly short, a few long) while idling is enabled
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!gaps_on) begin
      out_stall <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted access with the oldest prediction
  always @(posedge clk) begin : check_access
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_accesses.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("ERROR: access with none expected: addr %h wr %b data %h", bus_address,
                   bus_write, write_data);
      end else begin
        want = expected_accesses.pop_front();
        n_checked++;
        if (bus_address !== want.addr || bus_write !== want.write ||
            write_data !== want.wdata || dummy_cycle !== want.dummy ||
            last !== want.last || next_pc !== want.next_pc) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("ERROR: access %0d expected addr %h wr %b data %h dummy %b last %b pc %h",
                     n_checked, want.addr, want.write, want.wdata, want.dummy, want.last,
                     want.next_pc);
            $display("       got      addr %h wr %b data %h dummy %b last %b pc %h",
                     bus_address, bus_write, write_data, dummy_cycle, last, next_pc);
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d accesses still expected", cycles,
               expected_accesses.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // hold reset, release on an edge
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_steady_stream(40);
    test_output_holdoff(12);
    test_random_stores(700);

    // drain: wait for every predicted access, then for any stray access
    in_valid <= 1'b0;
    while (expected_accesses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d bus accesses (%0d dummy reads); dropped %0d idle data words, %0d restarts",
             n_checked, n_dummy, n_idle_drops, n_restarts);
    $display("Writes by mode zp..(zp),y: %0d %0d %0d %0d %0d %0d %0d %0d; errors %0d",
             writes_per_mode[0], writes_per_mode[1], writes_per_mode[2], writes_per_mode[3],
             writes_per_mode[4], writes_per_mode[5], writes_per_mode[6], writes_per_mode[7],
             n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
